### hw/rtl/lts_pkg.sv
// Shared types, constants and character tables of the lexical token scanner.
package lts_pkg;

	localparam int unsigned LINE_BITS_DEF   = 16;
	localparam int unsigned COLUMN_BITS_DEF = 12;
	localparam int unsigned LENGTH_BITS_DEF = 8;
	localparam int unsigned KIND_BITS       = 5;
	localparam int unsigned QUEUE_DEPTH     = 4;

	typedef logic [KIND_BITS-1:0] kind_t;

	localparam kind_t KIND_WORD     = 5'd0;
	localparam kind_t KIND_NUMBER   = 5'd1;
	localparam kind_t KIND_SPACE    = 5'd2;
	localparam kind_t KIND_LPAREN   = 5'd3;
	localparam kind_t KIND_RPAREN   = 5'd4;
	localparam kind_t KIND_LBRACE   = 5'd5;
	localparam kind_t KIND_RBRACE   = 5'd6;
	localparam kind_t KIND_COLON    = 5'd7;
	localparam kind_t KIND_SEMI     = 5'd8;
	localparam kind_t KIND_RBRACKET = 5'd9;
	localparam kind_t KIND_COMMA    = 5'd10;
	localparam kind_t KIND_PLUS     = 5'd11;
	localparam kind_t KIND_MINUS    = 5'd12;
	localparam kind_t KIND_STAR     = 5'd13;
	localparam kind_t KIND_SLASH    = 5'd14;
	localparam kind_t KIND_PERCENT  = 5'd15;
	localparam kind_t KIND_LBRACKET = 5'd16;
	localparam kind_t KIND_BRACKETS = 5'd17;
	localparam kind_t KIND_LT       = 5'd18;
	localparam kind_t KIND_LE       = 5'd19;
	localparam kind_t KIND_GT       = 5'd20;
	localparam kind_t KIND_GE       = 5'd21;
	localparam kind_t KIND_ASSIGN   = 5'd22;
	localparam kind_t KIND_EQ       = 5'd23;
	localparam kind_t KIND_NOT      = 5'd24;
	localparam kind_t KIND_NE       = 5'd25;
	localparam kind_t KIND_AND      = 5'd26;
	localparam kind_t KIND_OR       = 5'd27;
	localparam kind_t KIND_NONE     = 5'd31;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BANG  = 8'h21;

	typedef enum logic [2:0] {
		CLS_ALPHA,
		CLS_DIGIT,
		CLS_SPACE,
		CLS_MULTI,
		CLS_SINGLE,
		CLS_OTHER
	} cls_t;

	typedef enum logic [2:0] {
		MODE_START,
		MODE_WORD,
		MODE_NUMBER,
		MODE_SYMBOL,
		MODE_SPACE,
		MODE_ERROR
	} mode_t;

	typedef struct packed {
		logic       eoi;
		cls_t       cls;
		logic [7:0] ch;
		kind_t      skind;
	} item_t;

	function automatic kind_t single_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			8'h28:   k = KIND_LPAREN;
			8'h29:   k = KIND_RPAREN;
			8'h7B:   k = KIND_LBRACE;
			8'h7D:   k = KIND_RBRACE;
			8'h3A:   k = KIND_COLON;
			8'h3B:   k = KIND_SEMI;
			CH_RBRK: k = KIND_RBRACKET;
			8'h2C:   k = KIND_COMMA;
			8'h2B:   k = KIND_PLUS;
			8'h2D:   k = KIND_MINUS;
			8'h2A:   k = KIND_STAR;
			8'h2F:   k = KIND_SLASH;
			8'h25:   k = KIND_PERCENT;
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic kind_t lone_kind(input logic [7:0] p);
		kind_t k;
		case (p)
			CH_LBRK: k = KIND_LBRACKET;
			CH_LT:   k = KIND_LT;
			CH_GT:   k = KIND_GT;
			CH_EQ:   k = KIND_ASSIGN;
			CH_BANG: k = KIND_NOT;
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic kind_t pair_kind(input logic [7:0] p, input logic [7:0] c);
		kind_t k;
		k = KIND_NONE;
		if (p == CH_LBRK && c == CH_RBRK) k = KIND_BRACKETS;
		if (p == CH_LT && c == CH_EQ) k = KIND_LE;
		if (p == CH_GT && c == CH_EQ) k = KIND_GE;
		if (p == CH_EQ && c == CH_EQ) k = KIND_EQ;
		if (p == CH_BANG && c == CH_EQ) k = KIND_NE;
		if (p == CH_AMP && c == CH_AMP) k = KIND_AND;
		if (p == CH_BAR && c == CH_BAR) k = KIND_OR;
		return k;
	endfunction

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) r = CLS_ALPHA;
		else if (c >= 8'h30 && c <= 8'h39) r = CLS_DIGIT;
		else if (c == CH_SP || c == CH_TAB || c == CH_NL) r = CLS_SPACE;
		else if (c == CH_EQ || c == CH_LT || c == CH_GT || c == CH_LBRK || c == CH_AMP ||
			c == CH_BAR || c == CH_BANG) r = CLS_MULTI;
		else if (single_kind(c) != KIND_NONE) r = CLS_SINGLE;
		else r = CLS_OTHER;
		return r;
	endfunction

endpackage

### hw/rtl/lts_if.sv
// Byte input and result output channel interfaces of the lexical token scanner.
interface lts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_input;

	modport source (output valid, output char_code, output end_of_input, input ready);
	modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface lts_out_if #(
	parameter int unsigned LINE_BITS   = lts_pkg::LINE_BITS_DEF,
	parameter int unsigned COLUMN_BITS = lts_pkg::COLUMN_BITS_DEF,
	parameter int unsigned LENGTH_BITS = lts_pkg::LENGTH_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         status;
	logic [lts_pkg::KIND_BITS-1:0] token_kind;
	logic [LINE_BITS-1:0]         start_line;
	logic [COLUMN_BITS-1:0]       start_column;
	logic [LENGTH_BITS-1:0]       token_length;
	logic                         last_of_run;

	modport source (output valid, output status, output token_kind, output start_line,
		output start_column, output token_length, output last_of_run, input ready);
	modport sink (input valid, input status, input token_kind, input start_line,
		input start_column, input token_length, input last_of_run, output ready);
endinterface

### hw/rtl/lts_front.sv
// Front end: accepts bytes, tracks line and column, classifies and queues each request.
module lts_front #(
	parameter int unsigned LINE_BITS   = lts_pkg::LINE_BITS_DEF,
	parameter int unsigned COLUMN_BITS = lts_pkg::COLUMN_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	lts_in_if.sink                 in_ch,
	output lts_pkg::item_t         head,
	output logic [LINE_BITS-1:0]   head_line,
	output logic [COLUMN_BITS-1:0] head_col,
	output logic                   head_valid,
	input  logic                   pop
);
	import lts_pkg::*;

	localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	item_t                  item_q [QUEUE_DEPTH];
	logic [LINE_BITS-1:0]   line_q [QUEUE_DEPTH];
	logic [COLUMN_BITS-1:0] col_q  [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]    wr_q, rd_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic [LINE_BITS-1:0]   cur_line_q, pos_line;
	logic [COLUMN_BITS-1:0] cur_col_q, pos_col;
	logic                   push, do_pop;
	item_t                  new_item;

	assign in_ch.ready = cnt_q != CNT_BITS'(QUEUE_DEPTH);
	assign push        = in_ch.valid && in_ch.ready;
	assign head_valid  = cnt_q != '0;
	assign do_pop      = pop && head_valid;
	assign head        = item_q[rd_q];
	assign head_line   = line_q[rd_q];
	assign head_col    = col_q[rd_q];

	always_comb begin
		if (in_ch.char_code == CH_NL) begin
			pos_line = (cur_line_q == '1) ? cur_line_q : cur_line_q + 1'b1;
			pos_col  = '0;
		end else begin
			pos_line = cur_line_q;
			pos_col  = (cur_col_q == '1) ? cur_col_q : cur_col_q + 1'b1;
		end
		new_item.eoi   = in_ch.end_of_input;
		new_item.cls   = classify(in_ch.char_code);
		new_item.ch    = in_ch.char_code;
		new_item.skind = single_kind(in_ch.char_code);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q       <= '0;
			rd_q       <= '0;
			cnt_q      <= '0;
			cur_line_q <= LINE_BITS'(1);
			cur_col_q  <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
				if (in_ch.end_of_input) begin
					cur_line_q <= LINE_BITS'(1);
					cur_col_q  <= '0;
				end else begin
					cur_line_q <= pos_line;
					cur_col_q  <= pos_col;
				end
			end
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + CNT_BITS'(push) - CNT_BITS'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_q] <= new_item;
			line_q[wr_q] <= pos_line;
			col_q[wr_q]  <= pos_col;
		end
	end

endmodule

### hw/rtl/lts_back.sv
// Back end: token state machine over queued bytes and the result queue.
module lts_back #(
	parameter int unsigned LINE_BITS   = lts_pkg::LINE_BITS_DEF,
	parameter int unsigned COLUMN_BITS = lts_pkg::COLUMN_BITS_DEF,
	parameter int unsigned LENGTH_BITS = lts_pkg::LENGTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lts_pkg::item_t         head,
	input  logic [LINE_BITS-1:0]   head_line,
	input  logic [COLUMN_BITS-1:0] head_col,
	input  logic                   head_valid,
	output logic                   pop,
	lts_out_if.source              out_ch
);
	import lts_pkg::*;

	localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic                   status;
		kind_t                  kind;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		logic [LENGTH_BITS-1:0] len;
		logic                   last;
	} res_t;

	function automatic res_t make_token(input kind_t k, input logic [LINE_BITS-1:0] l,
		input logic [COLUMN_BITS-1:0] c, input logic [LENGTH_BITS-1:0] n);
		res_t r;
		r.status = 1'b0;
		r.kind   = k;
		r.line   = l;
		r.col    = c;
		r.len    = n;
		r.last   = 1'b0;
		return r;
	endfunction

	function automatic res_t make_error(input logic [LINE_BITS-1:0] l,
		input logic [COLUMN_BITS-1:0] c);
		res_t r;
		r.status = 1'b1;
		r.kind   = KIND_WORD;
		r.line   = l;
		r.col    = c;
		r.len    = '0;
		r.last   = 1'b0;
		return r;
	endfunction

	mode_t                  mode_q, mode_d;
	logic [7:0]             pend_q, pend_d;
	logic [LINE_BITS-1:0]   tok_line_q, tok_line_d;
	logic [COLUMN_BITS-1:0] tok_col_q, tok_col_d;
	logic [LENGTH_BITS-1:0] cnt_q, cnt_d, cnt_inc;
	res_t                   res_a, res_b, push0, push1;
	logic                   a_v, b_v, restart, cont;
	kind_t                  pk, lk, mode_kind;
	logic [CNT_BITS-1:0]    npush;

	res_t                   oq [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]    owr_q, ord_q;
	logic [CNT_BITS-1:0]    ocnt_q;
	logic                   opop;

	assign pop     = head_valid && (ocnt_q <= CNT_BITS'(QUEUE_DEPTH - 2));
	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
	assign pk      = pair_kind(pend_q, head.ch);
	assign lk      = lone_kind(pend_q);

	always_comb begin
		mode_d     = mode_q;
		pend_d     = pend_q;
		tok_line_d = tok_line_q;
		tok_col_d  = tok_col_q;
		cnt_d      = cnt_q;
		res_a      = '0;
		res_b      = '0;
		a_v        = 1'b0;
		b_v        = 1'b0;
		restart    = 1'b0;
		cont       = 1'b0;
		mode_kind  = KIND_WORD;
		if (mode_q == MODE_NUMBER) mode_kind = KIND_NUMBER;
		if (mode_q == MODE_SPACE) mode_kind = KIND_SPACE;
		if (head.eoi) begin
			unique case (mode_q)
				MODE_WORD, MODE_NUMBER, MODE_SPACE: begin
					a_v   = 1'b1;
					res_a = make_token(mode_kind, tok_line_q, tok_col_q, cnt_q);
				end
				MODE_SYMBOL: begin
					a_v = 1'b1;
					if (lk == KIND_NONE) res_a = make_error(tok_line_q, tok_col_q);
					else res_a = make_token(lk, tok_line_q, tok_col_q, cnt_q);
				end
				default: ;
			endcase
			mode_d = MODE_START;
		end else begin
			unique case (mode_q)
				MODE_START: restart = 1'b1;
				MODE_WORD, MODE_NUMBER, MODE_SPACE: begin
					if (mode_q == MODE_WORD)
						cont = head.cls == CLS_ALPHA || head.cls == CLS_DIGIT;
					else if (mode_q == MODE_NUMBER) cont = head.cls == CLS_DIGIT;
					else cont = head.cls == CLS_SPACE;
					if (cont) begin
						cnt_d = cnt_inc;
					end else begin
						a_v     = 1'b1;
						res_a   = make_token(mode_kind, tok_line_q, tok_col_q, cnt_q);
						restart = 1'b1;
					end
				end
				MODE_SYMBOL: begin
					a_v = 1'b1;
					if (pk != KIND_NONE) begin
						cnt_d  = cnt_inc;
						res_a  = make_token(pk, tok_line_q, tok_col_q, cnt_inc);
						mode_d = MODE_START;
					end else if (lk == KIND_NONE) begin
						res_a  = make_error(head_line, head_col);
						mode_d = MODE_ERROR;
					end else begin
						res_a   = make_token(lk, tok_line_q, tok_col_q, cnt_q);
						restart = 1'b1;
					end
				end
				default: mode_d = MODE_ERROR;
			endcase
			if (restart) begin
				tok_line_d = head_line;
				tok_col_d  = head_col;
				cnt_d      = LENGTH_BITS'(1);
				mode_d     = MODE_START;
				unique case (head.cls)
					CLS_ALPHA: mode_d = MODE_WORD;
					CLS_DIGIT: mode_d = MODE_NUMBER;
					CLS_SPACE: mode_d = MODE_SPACE;
					CLS_MULTI: begin
						mode_d = MODE_SYMBOL;
						pend_d = head.ch;
					end
					CLS_SINGLE: begin
						b_v   = 1'b1;
						res_b = make_token(head.skind, head_line, head_col, LENGTH_BITS'(1));
					end
					default: begin
						b_v    = 1'b1;
						res_b  = make_error(head_line, head_col);
						mode_d = MODE_ERROR;
					end
				endcase
			end
		end
		if (b_v) res_b.last = 1'b1;
		else res_a.last = 1'b1;
		push0 = a_v ? res_a : res_b;
		push1 = res_b;
		npush = pop ? CNT_BITS'(a_v) + CNT_BITS'(b_v) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_START;
			pend_q     <= '0;
			tok_line_q <= '0;
			tok_col_q  <= '0;
			cnt_q      <= '0;
		end else if (pop) begin
			mode_q     <= mode_d;
			pend_q     <= pend_d;
			tok_line_q <= tok_line_d;
			tok_col_q  <= tok_col_d;
			cnt_q      <= cnt_d;
		end
	end

	assign out_ch.valid        = ocnt_q != '0;
	assign opop                = out_ch.valid && out_ch.ready;
	assign out_ch.status       = oq[ord_q].status;
	assign out_ch.token_kind   = oq[ord_q].kind;
	assign out_ch.start_line   = oq[ord_q].line;
	assign out_ch.start_column = oq[ord_q].col;
	assign out_ch.token_length = oq[ord_q].len;
	assign out_ch.last_of_run  = oq[ord_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			owr_q <= owr_q + PTR_BITS'(npush);
			if (opop) ord_q <= ord_q + 1'b1;
			ocnt_q <= ocnt_q + npush - CNT_BITS'(opop);
		end
	end

	always_ff @(posedge clk) begin
		if (npush != '0) oq[owr_q] <= push0;
		if (npush == CNT_BITS'(2)) oq[owr_q + 1'b1] <= push1;
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= CNT_BITS'(QUEUE_DEPTH))
		else $error("Result queue count exceeds its depth.");

	a_room_for_two: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> ocnt_q <= CNT_BITS'(QUEUE_DEPTH - 2))
		else $error("Byte taken without room for two results.");

	a_error_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && mode_q == MODE_ERROR && !head.eoi) |=> mode_q == MODE_ERROR)
		else $error("Scanner left error mode before end of input.");

	a_eoi_start: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.eoi) |=> mode_q == MODE_START)
		else $error("End of input did not return the scanner to start.");

	a_error_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && mode_q == MODE_ERROR && !head.eoi) |-> npush == '0)
		else $error("Result produced while in error mode.");

endmodule

### hw/rtl/lexical_token_scanner.sv
// Lexical token scanner top level: front end, byte queue and token back end.
// The scanner takes one source byte per clock cycle while its byte queue has room. A byte
// passes the front end, which tracks line and column and classifies it, then a four-entry
// queue, then the token state machine, which places its results into a four-entry result
// queue; the output is presented from the head of that result queue. A byte that ends one
// token and is itself a one-byte token or an error yields two results, and the output port
// delivers one result per cycle while the receiver is ready, so the queues absorb the
// difference. Input and output stall independently.
module lexical_token_scanner #(
	parameter int unsigned LINE_BITS   = lts_pkg::LINE_BITS_DEF,
	parameter int unsigned COLUMN_BITS = lts_pkg::COLUMN_BITS_DEF,
	parameter int unsigned LENGTH_BITS = lts_pkg::LENGTH_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lts_in_if.sink    char_in,
	lts_out_if.source token_out
);
	import lts_pkg::*;

	item_t                  head;
	logic [LINE_BITS-1:0]   head_line;
	logic [COLUMN_BITS-1:0] head_col;
	logic                   head_valid;
	logic                   pop;

	lts_front #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (char_in),
		.head       (head),
		.head_line  (head_line),
		.head_col   (head_col),
		.head_valid (head_valid),
		.pop        (pop)
	);

	lts_back #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_line  (head_line),
		.head_col   (head_col),
		.head_valid (head_valid),
		.pop        (pop),
		.out_ch     (token_out)
	);

endmodule

### tb/sv/lts_token_checker.sv
// Token scanner checker: predicts results from accepted bytes and compares them in order.
`timescale 1ns / 1ps

module lts_token_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [7:0]                         char_code,
	input  logic                               end_of_input,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic                               status,
	input  logic [lts_pkg::KIND_BITS-1:0]       token_kind,
	input  logic [lts_pkg::LINE_BITS_DEF-1:0]   start_line,
	input  logic [lts_pkg::COLUMN_BITS_DEF-1:0] start_column,
	input  logic [lts_pkg::LENGTH_BITS_DEF-1:0] token_length,
	input  logic                               last_of_run,
	output int                                 mismatches,
	output int                                 waiting,
	output int                                 tokens_seen,
	output int                                 errors_seen
);
	import lts_pkg::*;

	typedef struct packed {
		logic                       status;
		kind_t                      kind;
		logic [LINE_BITS_DEF-1:0]   line;
		logic [COLUMN_BITS_DEF-1:0] col;
		logic [LENGTH_BITS_DEF-1:0] len;
		logic                       last;
	} token_rec_t;

	token_rec_t token_q[$];
	token_rec_t run_res[2];
	int         run_n;

	mode_t                      lex_mode;
	logic [7:0]                 held_sym;
	logic [LINE_BITS_DEF-1:0]   tok_line;
	logic [COLUMN_BITS_DEF-1:0] tok_col;
	logic [LENGTH_BITS_DEF-1:0] tok_len;
	logic [LINE_BITS_DEF-1:0]   cur_line;
	logic [COLUMN_BITS_DEF-1:0] cur_col;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == " " || c == "\t" || c == "\n";
	endfunction

	function automatic logic is_pairable(input logic [7:0] c);
		return c == "=" || c == "<" || c == ">" || c == "[" || c == "&" || c == "|" ||
			c == "!";
	endfunction

	function automatic kind_t sym_kind(input logic [7:0] c);
		case (c)
			"(": return KIND_LPAREN;
			")": return KIND_RPAREN;
			"{": return KIND_LBRACE;
			"}": return KIND_RBRACE;
			":": return KIND_COLON;
			";": return KIND_SEMI;
			"]": return KIND_RBRACKET;
			",": return KIND_COMMA;
			"+": return KIND_PLUS;
			"-": return KIND_MINUS;
			"*": return KIND_STAR;
			"/": return KIND_SLASH;
			"%": return KIND_PERCENT;
			default: return KIND_NONE;
		endcase
	endfunction

	function automatic kind_t lone_op_kind(input logic [7:0] p);
		case (p)
			"[": return KIND_LBRACKET;
			"<": return KIND_LT;
			">": return KIND_GT;
			"=": return KIND_ASSIGN;
			"!": return KIND_NOT;
			default: return KIND_NONE;
		endcase
	endfunction

	function automatic kind_t op_pair_kind(input logic [7:0] p, input logic [7:0] c);
		if (p == "[" && c == "]") return KIND_BRACKETS;
		if (p == "<" && c == "=") return KIND_LE;
		if (p == ">" && c == "=") return KIND_GE;
		if (p == "=" && c == "=") return KIND_EQ;
		if (p == "!" && c == "=") return KIND_NE;
		if (p == "&" && c == "&") return KIND_AND;
		if (p == "|" && c == "|") return KIND_OR;
		return KIND_NONE;
	endfunction

	task automatic add_token(input kind_t k);
		run_res[run_n] = '{1'b0, k, tok_line, tok_col, tok_len, 1'b0};
		run_n++;
	endtask

	task automatic add_error(input logic [LINE_BITS_DEF-1:0] ln,
		input logic [COLUMN_BITS_DEF-1:0] cl);
		run_res[run_n] = '{1'b1, KIND_WORD, ln, cl, '0, 1'b0};
		run_n++;
	endtask

	task automatic scan_byte(input logic [7:0] c, input logic eoi);
		logic  again;
		logic  cont;
		kind_t k;
		run_n = 0;
		if (eoi) begin
			case (lex_mode)
				MODE_WORD: add_token(KIND_WORD);
				MODE_NUMBER: add_token(KIND_NUMBER);
				MODE_SPACE: add_token(KIND_SPACE);
				MODE_SYMBOL: begin
					k = lone_op_kind(held_sym);
					if (k == KIND_NONE) add_error(tok_line, tok_col);
					else add_token(k);
				end
				default: ;
			endcase
			lex_mode = MODE_START;
			cur_line = LINE_BITS_DEF'(1);
			cur_col = '0;
		end else begin
			if (c == "\n") begin
				if (cur_line != '1) cur_line++;
				cur_col = '0;
			end else if (cur_col != '1) begin
				cur_col++;
			end
			again = 1'b1;
			while (again) begin
				again = 1'b0;
				case (lex_mode)
					MODE_START: begin
						tok_line = cur_line;
						tok_col = cur_col;
						tok_len = LENGTH_BITS_DEF'(1);
						k = sym_kind(c);
						if (is_letter(c)) lex_mode = MODE_WORD;
						else if (is_digit(c)) lex_mode = MODE_NUMBER;
						else if (is_blank(c)) lex_mode = MODE_SPACE;
						else if (is_pairable(c)) begin
							lex_mode = MODE_SYMBOL;
							held_sym = c;
						end else if (k != KIND_NONE) begin
							add_token(k);
						end else begin
							add_error(cur_line, cur_col);
							lex_mode = MODE_ERROR;
						end
					end
					MODE_WORD, MODE_NUMBER, MODE_SPACE: begin
						case (lex_mode)
							MODE_WORD: cont = is_letter(c) || is_digit(c);
							MODE_NUMBER: cont = is_digit(c);
							default: cont = is_blank(c);
						endcase
						if (cont) begin
							if (tok_len != '1) tok_len++;
						end else begin
							add_token(lex_mode == MODE_WORD ? KIND_WORD :
								(lex_mode == MODE_NUMBER ? KIND_NUMBER : KIND_SPACE));
							lex_mode = MODE_START;
							again = 1'b1;
						end
					end
					MODE_SYMBOL: begin
						k = op_pair_kind(held_sym, c);
						if (k != KIND_NONE) begin
							if (tok_len != '1) tok_len++;
							add_token(k);
							lex_mode = MODE_START;
						end else begin
							k = lone_op_kind(held_sym);
							if (k == KIND_NONE) begin
								add_error(cur_line, cur_col);
								lex_mode = MODE_ERROR;
							end else begin
								add_token(k);
								lex_mode = MODE_START;
								again = 1'b1;
							end
						end
					end
					default: lex_mode = MODE_ERROR;
				endcase
			end
		end
		for (int i = 0; i < run_n; i++) begin
			run_res[i].last = (i == run_n - 1);
			token_q = {token_q, run_res[i]};
		end
	endtask

	task automatic check_result();
		token_rec_t want;
		if (token_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with nothing expected: status=%0d kind=%0d ",
					$time, status, token_kind,
					"line=%0d col=%0d len=%0d last=%0d",
					start_line, start_column, token_length, last_of_run);
		end else begin
			want = token_q.pop_front();
			if (status !== want.status || token_kind !== want.kind ||
				start_line !== want.line || start_column !== want.col ||
				token_length !== want.len || last_of_run !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch: expected status=%0d kind=%0d line=%0d ",
						$time, want.status, want.kind, want.line,
						"col=%0d len=%0d last=%0d", want.col, want.len, want.last);
					$display("%0t: mismatch: got status=%0d kind=%0d line=%0d ",
						$time, status, token_kind, start_line,
						"col=%0d len=%0d last=%0d", start_column, token_length,
						last_of_run);
				end
			end else if (want.status) begin
				errors_seen++;
			end else begin
				tokens_seen++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q.delete();
			lex_mode = MODE_START;
			held_sym = '0;
			tok_line = '0;
			tok_col = '0;
			tok_len = '0;
			cur_line = LINE_BITS_DEF'(1);
			cur_col = '0;
			mismatches = 0;
			waiting = 0;
			tokens_seen = 0;
			errors_seen = 0;
		end else begin
			if (in_valid && in_ready) scan_byte(char_code, end_of_input);
			if (out_valid && out_ready) check_result();
			waiting = token_q.size();
		end
	end

endmodule

### tb/sv/tb_lexical_token_scanner.sv
// Testbench top of the lexical token scanner: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_lexical_token_scanner;
	import lts_pkg::*;

	logic clk;
	logic arst_n;

	int gap_pct;
	int stall_pct;
	int bytes_sent;
	int runs_sent;

	int mismatches;
	int waiting;
	int tokens_seen;
	int errors_seen;

	int gap_tab[4]   = '{0, 62, 0, 23};
	int stall_tab[4] = '{0, 0, 62, 23};

	string      single_set = "(){}:;],+-*/%";
	string      pair_set   = "[]<=>===!=&&||";
	string      lone_set   = "[<>=!";
	logic [7:0] blank_set[3] = '{CH_SP, CH_TAB, CH_NL};

	lts_in_if  in_ch ();
	lts_out_if out_ch ();

	lexical_token_scanner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (in_ch),
		.token_out (out_ch)
	);

	lts_token_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.char_code    (in_ch.char_code),
		.end_of_input (in_ch.end_of_input),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.status       (out_ch.status),
		.token_kind   (out_ch.token_kind),
		.start_line   (out_ch.start_line),
		.start_column (out_ch.start_column),
		.token_length (out_ch.token_length),
		.last_of_run  (out_ch.last_of_run),
		.mismatches   (mismatches),
		.waiting      (waiting),
		.tokens_seen  (tokens_seen),
		.errors_seen  (errors_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ch.ready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic logic [7:0] letter();
		if ($urandom_range(0, 1)) return 8'("A" + $urandom_range(0, 25));
		return 8'("a" + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic eoi);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.char_code <= c;
		in_ch.end_of_input <= eoi;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (eoi) runs_sent++;
		else bytes_sent++;
	endtask

	task automatic send_eoi();
		send_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	task automatic send_repeat(input logic [7:0] c, input int n);
		repeat (n) send_byte(c, 1'b0);
	endtask

	task automatic send_lexeme();
		int pick;
		int len;
		int j;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			len = ($urandom_range(0, 49) == 0) ? $urandom_range(250, 270) : $urandom_range(1, 8);
			send_byte(letter(), 1'b0);
			for (j = 1; j < len; j++)
				send_byte(($urandom_range(0, 3) == 0) ? digit() : letter(), 1'b0);
		end else if (pick < 40) begin
			repeat ($urandom_range(1, 6)) send_byte(digit(), 1'b0);
		end else if (pick < 55) begin
			repeat ($urandom_range(1, 3)) send_byte(blank_set[$urandom_range(0, 2)], 1'b0);
		end else if (pick < 70) begin
			send_byte(single_set[$urandom_range(0, 12)], 1'b0);
		end else if (pick < 85) begin
			j = 2 * $urandom_range(0, 6);
			send_byte(pair_set[j], 1'b0);
			send_byte(pair_set[j + 1], 1'b0);
		end else if (pick < 94) begin
			send_byte(lone_set[$urandom_range(0, 4)], 1'b0);
		end else if (pick < 97) begin
			send_byte($urandom_range(0, 1) ? CH_AMP : CH_BAR, 1'b0);
		end else begin
			send_byte(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	initial begin
		int phase_start;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.char_code <= '0;
		in_ch.end_of_input <= 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		bytes_sent = 0;
		runs_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("Az9 0\t(){}:;],+-*/%");
		send_eoi();
		send_text("[]<=>===!=&&||[ < > = !");
		send_eoi();
		send_text("&x zz");
		send_eoi();
		send_text("a|");
		send_eoi();
		send_byte(8'h80, 1'b0);
		send_text("q");
		send_eoi();
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_repeat("a", 260);
		send_text("+");
		send_eoi();
		send_repeat(CH_NL, 3);
		send_text("b");
		send_eoi();

		for (int p = 0; p < 4; p++) begin
			gap_pct = gap_tab[p];
			stall_pct = stall_tab[p];
			phase_start = bytes_sent + runs_sent;
			while (bytes_sent + runs_sent - phase_start < 430) begin
				repeat ($urandom_range(1, 10)) send_lexeme();
				send_eoi();
			end
		end
		in_ch.valid <= 1'b0;
		stall_pct = 0;

		while (waiting != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("Scanned %0d bytes in %0d end-of-input runs; %0d tokens, %0d errors matched.",
			bytes_sent, runs_sent, tokens_seen, errors_seen);
		$display("Pacing phases: free flow, sender gaps, receiver stalls, both; length saturation included.");
		if (mismatches == 0 && waiting == 0) begin
			$display("tb_lexical_token_scanner OK");
		end else begin
			$display("tb_lexical_token_scanner NOT OK");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("tb_lexical_token_scanner NOT OK");
		$finish;
	end

endmodule
